[rtl/mos_pkg.sv]
// Package for the 6502 subset core: payload types, opcodes, codes and flag helpers.
// Used by every RTL file of the core except mos_ram; depends on nothing.
`default_nettype none

package mos_pkg;

    localparam int MEM_DEPTH = 65536;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam logic [16:0] DEPTH_LIM = 17'(MEM_DEPTH);

    localparam logic [1:0] FN_LOAD  = 2'd0;
    localparam logic [1:0] FN_RESET = 2'd1;
    localparam logic [1:0] FN_EXEC  = 2'd2;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_ADDR = 2'd1;
    localparam logic [1:0] ERR_OP   = 2'd2;

    localparam logic [7:0] SP_RESET   = 8'hFF;
    localparam logic [7:0] STACK_PAGE = 8'h01;
    localparam logic [7:0] ZERO_PAGE  = 8'h00;
    localparam logic [7:0] FLAG_N     = 8'b1000_0000;
    localparam logic [7:0] FLAG_V     = 8'b0100_0000;
    localparam logic [7:0] FLAG_D     = 8'b0000_1000;
    localparam logic [7:0] FLAG_I     = 8'b0000_0100;
    localparam logic [7:0] FLAG_Z     = 8'b0000_0010;
    localparam logic [7:0] FLAG_C     = 8'b0000_0001;
    localparam logic [7:0] FLAG_MASK  = 8'hDF;

    localparam logic [7:0] OPC_CLC   = 8'h18;
    localparam logic [7:0] OPC_CLD   = 8'hD8;
    localparam logic [7:0] OPC_CLI   = 8'h58;
    localparam logic [7:0] OPC_CLV   = 8'hB8;
    localparam logic [7:0] OPC_CMP_I = 8'hC9;
    localparam logic [7:0] OPC_CMP_Z = 8'hC5;
    localparam logic [7:0] OPC_CMP_A = 8'hCD;
    localparam logic [7:0] OPC_CPX_I = 8'hE0;
    localparam logic [7:0] OPC_CPX_Z = 8'hE4;
    localparam logic [7:0] OPC_CPX_A = 8'hEC;
    localparam logic [7:0] OPC_CPY_I = 8'hC0;
    localparam logic [7:0] OPC_CPY_Z = 8'hC4;
    localparam logic [7:0] OPC_CPY_A = 8'hCC;
    localparam logic [7:0] OPC_DEC_Z = 8'hC6;
    localparam logic [7:0] OPC_DEC_A = 8'hCE;
    localparam logic [7:0] OPC_INC_Z = 8'hE6;
    localparam logic [7:0] OPC_INC_A = 8'hEE;
    localparam logic [7:0] OPC_LSR_Z = 8'h46;
    localparam logic [7:0] OPC_LSR_A = 8'h4E;
    localparam logic [7:0] OPC_LSR_R = 8'h4A;
    localparam logic [7:0] OPC_DEX   = 8'hCA;
    localparam logic [7:0] OPC_DEY   = 8'h88;
    localparam logic [7:0] OPC_INX   = 8'hE8;
    localparam logic [7:0] OPC_INY   = 8'hC8;
    localparam logic [7:0] OPC_EOR_I = 8'h49;
    localparam logic [7:0] OPC_EOR_Z = 8'h45;
    localparam logic [7:0] OPC_EOR_A = 8'h4D;
    localparam logic [7:0] OPC_LDA_I = 8'hA9;
    localparam logic [7:0] OPC_LDA_Z = 8'hA5;
    localparam logic [7:0] OPC_LDX_I = 8'hA2;
    localparam logic [7:0] OPC_LDX_Z = 8'hA6;
    localparam logic [7:0] OPC_LDY_I = 8'hA0;
    localparam logic [7:0] OPC_LDY_Z = 8'hA4;
    localparam logic [7:0] OPC_JMP   = 8'h4C;
    localparam logic [7:0] OPC_JSR   = 8'h20;
    localparam logic [7:0] OPC_RTS   = 8'h60;
    localparam logic [7:0] OPC_NOP   = 8'hEA;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] load_address;
        logic [7:0]  load_data;
    } t_in;

    typedef struct packed {
        logic [15:0] program_counter;
        logic [7:0]  accumulator;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  stack_pointer;
        logic [7:0]  status_flags;
        logic [7:0]  opcode_done;
        logic [1:0]  error_code;
    } t_out;

    typedef enum logic [4:0] {
        K_BAD, K_CLC, K_CLD, K_CLI, K_CLV, K_CMP, K_CPX, K_CPY, K_DEC, K_INC,
        K_LSRM, K_LSRA, K_DEX, K_DEY, K_INX, K_INY, K_EOR, K_LDA, K_LDX, K_LDY,
        K_JMP, K_JSR, K_RTS, K_NOP
    } t_kind;

    typedef enum logic [1:0] {M_IMP, M_IMM, M_ZP, M_ABS} t_mode;

    typedef struct packed {
        t_kind kind;
        t_mode mode;
    } t_dec;

    typedef enum logic [1:0] {RS_PC, RS_ZP, RS_ABS, RS_STK} t_rsel;
    typedef enum logic [1:0] {WS_ALU, WS_RET_HI, WS_RET_LO} t_wsel;

    typedef enum logic [3:0] {
        S_IDLE, S_OPC, S_OP1, S_OP2, S_MEM, S_POP1, S_POP2, S_PUSH1, S_PUSH2, S_FIN
    } t_state;

    typedef struct packed {
        logic  start;
        logic  load_wr;
        logic  do_reset;
        logic  rd_en;
        t_rsel rd_sel;
        logic  pc_inc;
        logic  latch_op;
        logic  latch_lo;
        logic  set_ea_zp;
        logic  set_ea_abs;
        logic  set_ret;
        logic  exec_imp;
        logic  exec_val;
        logic  wr_en;
        t_wsel wr_sel;
        logic  sp_inc;
        logic  sp_dec;
        logic  pc_jmp;
        logic  pc_ea;
        logic  pc_pop;
        logic  set_bad;
        logic  set_unk;
        logic  finish;
    } t_cmd;

    typedef struct packed {
        logic  rd_ok;
        logic  ld_ok;
        logic  stk_ok;
        t_kind kind;
        t_mode mode;
    } t_sts;

    function automatic logic [7:0] f_zn(input logic [7:0] f, input logic [7:0] v);
        logic [7:0] g;
        g = f & ~(FLAG_N | FLAG_Z);
        if (v == 8'd0) g = g | FLAG_Z;
        g = g | (v & FLAG_N);
        return g;
    endfunction

    function automatic logic [7:0] f_cmp(input logic [7:0] f, input logic [7:0] r,
                                         input logic [7:0] v);
        logic [7:0] g;
        g = f_zn(f, 8'(r - v));
        g = g & ~FLAG_C;
        if (r >= v) g = g | FLAG_C;
        return g;
    endfunction

    function automatic logic [7:0] f_lsr(input logic [7:0] f, input logic [7:0] old);
        logic [7:0] g;
        g = f & ~(FLAG_N | FLAG_Z | FLAG_C);
        g = g | (old & FLAG_C);
        if (old[7:1] == 7'd0) g = g | FLAG_Z;
        return g;
    endfunction

    function automatic t_dec f_decode(input logic [7:0] op);
        t_dec d;
        d.kind = K_BAD;
        d.mode = M_IMP;
        case (op)
            OPC_CLC:   d.kind = K_CLC;
            OPC_CLD:   d.kind = K_CLD;
            OPC_CLI:   d.kind = K_CLI;
            OPC_CLV:   d.kind = K_CLV;
            OPC_CMP_I: begin d.kind = K_CMP; d.mode = M_IMM; end
            OPC_CMP_Z: begin d.kind = K_CMP; d.mode = M_ZP; end
            OPC_CMP_A: begin d.kind = K_CMP; d.mode = M_ABS; end
            OPC_CPX_I: begin d.kind = K_CPX; d.mode = M_IMM; end
            OPC_CPX_Z: begin d.kind = K_CPX; d.mode = M_ZP; end
            OPC_CPX_A: begin d.kind = K_CPX; d.mode = M_ABS; end
            OPC_CPY_I: begin d.kind = K_CPY; d.mode = M_IMM; end
            OPC_CPY_Z: begin d.kind = K_CPY; d.mode = M_ZP; end
            OPC_CPY_A: begin d.kind = K_CPY; d.mode = M_ABS; end
            OPC_DEC_Z: begin d.kind = K_DEC; d.mode = M_ZP; end
            OPC_DEC_A: begin d.kind = K_DEC; d.mode = M_ABS; end
            OPC_INC_Z: begin d.kind = K_INC; d.mode = M_ZP; end
            OPC_INC_A: begin d.kind = K_INC; d.mode = M_ABS; end
            OPC_LSR_Z: begin d.kind = K_LSRM; d.mode = M_ZP; end
            OPC_LSR_A: begin d.kind = K_LSRM; d.mode = M_ABS; end
            OPC_LSR_R: d.kind = K_LSRA;
            OPC_DEX:   d.kind = K_DEX;
            OPC_DEY:   d.kind = K_DEY;
            OPC_INX:   d.kind = K_INX;
            OPC_INY:   d.kind = K_INY;
            OPC_EOR_I: begin d.kind = K_EOR; d.mode = M_IMM; end
            OPC_EOR_Z: begin d.kind = K_EOR; d.mode = M_ZP; end
            OPC_EOR_A: begin d.kind = K_EOR; d.mode = M_ABS; end
            OPC_LDA_I: begin d.kind = K_LDA; d.mode = M_IMM; end
            OPC_LDA_Z: begin d.kind = K_LDA; d.mode = M_ZP; end
            OPC_LDX_I: begin d.kind = K_LDX; d.mode = M_IMM; end
            OPC_LDX_Z: begin d.kind = K_LDX; d.mode = M_ZP; end
            OPC_LDY_I: begin d.kind = K_LDY; d.mode = M_IMM; end
            OPC_LDY_Z: begin d.kind = K_LDY; d.mode = M_ZP; end
            OPC_JMP:   begin d.kind = K_JMP; d.mode = M_ABS; end
            OPC_JSR:   begin d.kind = K_JSR; d.mode = M_ABS; end
            OPC_RTS:   d.kind = K_RTS;
            OPC_NOP:   d.kind = K_NOP;
            default:   d.kind = K_BAD;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/mos6502_subset_core_top.sv]
// Top level of the 6502 subset core: joins the controller and the datapath.
// Depends on mos_pkg, mos_ctrl, mos_dpath and mos_ram.
`default_nettype none

// Each input beat loads one memory byte, resets the registers, executes one instruction
// at PC, or (for the unused func code) changes nothing, and yields exactly one result
// beat with the registers and an error code. Items are worked one at a time, and every
// opcode fetch, operand fetch, data access and stack access goes through the single
// port of the internal memory. A finished result waits in the output register while
// the next item is taken in. Memory is not cleared by reset.
module mos6502_subset_core_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire mos_pkg::t_in i_data,
    output logic              o_valid,
    input  wire logic         i_stall,
    output mos_pkg::t_out     o_data
);
    import mos_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    mos_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_func  (i_data.func),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    mos_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_in    (i_data),
        .o_sts   (w_sts),
        .o_out   (o_data)
    );

endmodule

`default_nettype wire

[rtl/mos_ram.sv]
// Generic single-port RAM with a registered read.
// Stand-alone; width and depth come from its parameters.
`default_nettype none

module mos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/mos_dpath.sv]
// Datapath of the 6502 subset core: registers, working copies, address muxing and memory.
// Depends on mos_pkg and mos_ram; driven by commands from mos_ctrl.
`default_nettype none

module mos_dpath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mos_pkg::t_cmd i_cmd,
    input  wire mos_pkg::t_in  i_in,
    output mos_pkg::t_sts      o_sts,
    output mos_pkg::t_out      o_out
);
    import mos_pkg::*;

    logic [15:0] r_pc, r_pc_w, n_pc_w;
    logic [7:0]  r_sp, r_sp_w, n_sp_w;
    logic [7:0]  r_a, r_a_w, n_a_w;
    logic [7:0]  r_x, r_x_w, n_x_w;
    logic [7:0]  r_y, r_y_w, n_y_w;
    logic [7:0]  r_f, r_f_w, n_f_w;
    logic [7:0]  r_op, n_op;
    logic [7:0]  r_opd, n_opd;
    logic [7:0]  r_lo, n_lo;
    logic [15:0] r_ea, n_ea;
    logic [15:0] r_ret, n_ret;
    logic        r_bad, n_bad;
    logic        r_unk, n_unk;
    t_out        r_out;

    logic [7:0]  w_rdata, w_wdata, w_alu;
    logic [15:0] w_raddr, w_waddr, w_maddr, w_stk;
    logic        w_we;
    t_dec        w_dec;

    assign w_dec = f_decode(i_cmd.latch_op ? w_rdata : r_op);
    assign w_stk = {STACK_PAGE, r_sp_w};

    always_comb begin
        case (i_cmd.rd_sel)
            RS_PC:   w_raddr = r_pc_w;
            RS_ZP:   w_raddr = {ZERO_PAGE, w_rdata};
            RS_ABS:  w_raddr = {w_rdata, r_lo};
            RS_STK:  w_raddr = {STACK_PAGE, 8'(r_sp_w + 8'd1)};
            default: w_raddr = r_pc_w;
        endcase
    end

    always_comb begin
        case (w_dec.kind)
            K_DEC:   w_alu = 8'(w_rdata - 8'd1);
            K_INC:   w_alu = 8'(w_rdata + 8'd1);
            default: w_alu = {1'b0, w_rdata[7:1]};
        endcase
    end

    always_comb begin
        w_waddr = (i_cmd.wr_sel == WS_ALU) ? r_ea : w_stk;
        case (i_cmd.wr_sel)
            WS_ALU:    w_wdata = w_alu;
            WS_RET_HI: w_wdata = r_ret[15:8];
            WS_RET_LO: w_wdata = r_ret[7:0];
            default:   w_wdata = w_alu;
        endcase
        if (i_cmd.load_wr) begin
            w_waddr = i_in.load_address;
            w_wdata = i_in.load_data;
        end
    end

    assign o_sts.rd_ok  = ({1'b0, w_raddr} < DEPTH_LIM);
    assign o_sts.ld_ok  = ({1'b0, i_in.load_address} < DEPTH_LIM);
    assign o_sts.stk_ok = ({1'b0, w_stk} < DEPTH_LIM);
    assign o_sts.kind   = w_dec.kind;
    assign o_sts.mode   = w_dec.mode;

    assign w_we    = (i_cmd.load_wr && o_sts.ld_ok) || i_cmd.wr_en;
    assign w_maddr = (i_cmd.load_wr || i_cmd.wr_en) ? w_waddr : w_raddr;

    mos_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_maddr[ADDR_W-1:0]),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_pc_w = r_pc_w;
        n_sp_w = r_sp_w;
        n_a_w  = r_a_w;
        n_x_w  = r_x_w;
        n_y_w  = r_y_w;
        n_f_w  = r_f_w;
        n_op   = r_op;
        n_opd  = r_opd;
        n_lo   = r_lo;
        n_ea   = r_ea;
        n_ret  = r_ret;
        n_bad  = r_bad;
        n_unk  = r_unk;
        if (i_cmd.start) begin
            n_bad = 1'b0;
            n_unk = 1'b0;
            n_opd = 8'd0;
        end
        if (i_cmd.latch_op) begin
            n_op  = w_rdata;
            n_opd = w_rdata;
        end
        if (i_cmd.pc_inc)     n_pc_w = 16'(r_pc_w + 16'd1);
        if (i_cmd.pc_jmp)     n_pc_w = {w_rdata, r_lo};
        if (i_cmd.pc_ea)      n_pc_w = r_ea;
        if (i_cmd.pc_pop)     n_pc_w = 16'({w_rdata, r_lo} + 16'd1);
        if (i_cmd.latch_lo)   n_lo = w_rdata;
        if (i_cmd.set_ea_zp)  n_ea = {ZERO_PAGE, w_rdata};
        if (i_cmd.set_ea_abs) n_ea = {w_rdata, r_lo};
        if (i_cmd.set_ret)    n_ret = 16'(r_pc_w - 16'd1);
        if (i_cmd.sp_inc)     n_sp_w = 8'(r_sp_w + 8'd1);
        if (i_cmd.sp_dec)     n_sp_w = 8'(r_sp_w - 8'd1);
        if (i_cmd.exec_imp) begin
            case (w_dec.kind)
                K_CLC:  n_f_w = r_f_w & ~FLAG_C;
                K_CLD:  n_f_w = r_f_w & ~FLAG_D;
                K_CLI:  n_f_w = r_f_w & ~FLAG_I;
                K_CLV:  n_f_w = r_f_w & ~FLAG_V;
                K_LSRA: begin
                    n_f_w = f_lsr(r_f_w, r_a_w);
                    n_a_w = {1'b0, r_a_w[7:1]};
                end
                K_DEX: begin
                    n_x_w = 8'(r_x_w - 8'd1);
                    n_f_w = f_zn(r_f_w, n_x_w);
                end
                K_DEY: begin
                    n_y_w = 8'(r_y_w - 8'd1);
                    n_f_w = f_zn(r_f_w, n_y_w);
                end
                K_INX: begin
                    n_x_w = 8'(r_x_w + 8'd1);
                    n_f_w = f_zn(r_f_w, n_x_w);
                end
                K_INY: begin
                    n_y_w = 8'(r_y_w + 8'd1);
                    n_f_w = f_zn(r_f_w, n_y_w);
                end
                default: ;
            endcase
        end
        if (i_cmd.exec_val) begin
            case (w_dec.kind)
                K_CMP: n_f_w = f_cmp(r_f_w, r_a_w, w_rdata);
                K_CPX: n_f_w = f_cmp(r_f_w, r_x_w, w_rdata);
                K_CPY: n_f_w = f_cmp(r_f_w, r_y_w, w_rdata);
                K_EOR: begin
                    n_a_w = r_a_w ^ w_rdata;
                    n_f_w = f_zn(r_f_w, n_a_w);
                end
                K_LDA: begin
                    n_a_w = w_rdata;
                    n_f_w = f_zn(r_f_w, w_rdata);
                end
                K_LDX: begin
                    n_x_w = w_rdata;
                    n_f_w = f_zn(r_f_w, w_rdata);
                end
                K_LDY: begin
                    n_y_w = w_rdata;
                    n_f_w = f_zn(r_f_w, w_rdata);
                end
                K_DEC, K_INC: n_f_w = f_zn(r_f_w, w_alu);
                K_LSRM:       n_f_w = f_lsr(r_f_w, w_rdata);
                default: ;
            endcase
        end
        if (i_cmd.do_reset) begin
            n_pc_w = 16'd0;
            n_sp_w = SP_RESET;
            n_a_w  = 8'd0;
            n_x_w  = 8'd0;
            n_y_w  = 8'd0;
            n_f_w  = 8'd0;
        end
        if (i_cmd.set_bad) n_bad = 1'b1;
        if (i_cmd.set_unk) n_unk = 1'b1;
        if (i_cmd.finish && r_bad) begin
            n_pc_w = r_pc;
            n_sp_w = r_sp;
            n_a_w  = r_a;
            n_x_w  = r_x;
            n_y_w  = r_y;
            n_f_w  = r_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= 16'd0;
            r_sp   <= SP_RESET;
            r_a    <= 8'd0;
            r_x    <= 8'd0;
            r_y    <= 8'd0;
            r_f    <= 8'd0;
            r_pc_w <= 16'd0;
            r_sp_w <= SP_RESET;
            r_a_w  <= 8'd0;
            r_x_w  <= 8'd0;
            r_y_w  <= 8'd0;
            r_f_w  <= 8'd0;
            r_bad  <= 1'b0;
            r_unk  <= 1'b0;
        end else begin
            r_pc_w <= n_pc_w;
            r_sp_w <= n_sp_w;
            r_a_w  <= n_a_w;
            r_x_w  <= n_x_w;
            r_y_w  <= n_y_w;
            r_f_w  <= n_f_w;
            r_bad  <= n_bad;
            r_unk  <= n_unk;
            if (i_cmd.finish && !r_bad) begin
                r_pc <= r_pc_w;
                r_sp <= r_sp_w;
                r_a  <= r_a_w;
                r_x  <= r_x_w;
                r_y  <= r_y_w;
                r_f  <= r_f_w & FLAG_MASK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_opd <= n_opd;
        r_lo  <= n_lo;
        r_ea  <= n_ea;
        r_ret <= n_ret;
        if (i_cmd.finish) begin
            r_out.program_counter <= r_bad ? r_pc : r_pc_w;
            r_out.accumulator     <= r_bad ? r_a : r_a_w;
            r_out.index_x         <= r_bad ? r_x : r_x_w;
            r_out.index_y         <= r_bad ? r_y : r_y_w;
            r_out.stack_pointer   <= r_bad ? r_sp : r_sp_w;
            r_out.status_flags    <= (r_bad ? r_f : r_f_w) & FLAG_MASK;
            r_out.opcode_done     <= r_opd;
            r_out.error_code      <= r_bad ? ERR_ADDR : (r_unk ? ERR_OP : ERR_OK);
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

[rtl/mos_ctrl.sv]
// Controller of the 6502 subset core: instruction sequencing state machine and output valid.
// Depends on mos_pkg; steers mos_dpath through command and status structs.
`default_nettype none

module mos_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [1:0]    i_func,
    output logic               o_valid,
    input  wire logic          i_stall,
    input  wire mos_pkg::t_sts i_sts,
    output mos_pkg::t_cmd      o_cmd
);
    import mos_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_acc, w_out_free;

    assign w_acc      = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = (i_func == FN_EXEC && i_sts.rd_ok) ? S_OPC : S_FIN;
                end
            end
            S_OPC: begin
                if (i_sts.kind == K_BAD) begin
                    n_state = S_FIN;
                end else if (i_sts.mode == M_IMP) begin
                    n_state = (i_sts.kind == K_RTS && i_sts.rd_ok) ? S_POP1 : S_FIN;
                end else begin
                    n_state = i_sts.rd_ok ? S_OP1 : S_FIN;
                end
            end
            S_OP1: begin
                case (i_sts.mode)
                    M_ZP:    n_state = i_sts.rd_ok ? S_MEM : S_FIN;
                    M_ABS:   n_state = i_sts.rd_ok ? S_OP2 : S_FIN;
                    default: n_state = S_FIN;
                endcase
            end
            S_OP2: begin
                if (i_sts.kind == K_JMP) begin
                    n_state = S_FIN;
                end else if (i_sts.kind == K_JSR) begin
                    n_state = i_sts.stk_ok ? S_PUSH1 : S_FIN;
                end else begin
                    n_state = i_sts.rd_ok ? S_MEM : S_FIN;
                end
            end
            S_MEM:   n_state = S_FIN;
            S_POP1:  n_state = i_sts.rd_ok ? S_POP2 : S_FIN;
            S_POP2:  n_state = S_FIN;
            S_PUSH1: n_state = S_PUSH2;
            S_PUSH2: n_state = S_FIN;
            S_FIN:   n_state = w_out_free ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.start = 1'b1;
                    case (i_func)
                        FN_LOAD: begin
                            o_cmd.load_wr = 1'b1;
                            o_cmd.set_bad = !i_sts.ld_ok;
                        end
                        FN_RESET: o_cmd.do_reset = 1'b1;
                        FN_EXEC: begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_sel  = RS_PC;
                            o_cmd.pc_inc  = 1'b1;
                            o_cmd.set_bad = !i_sts.rd_ok;
                        end
                        default: ;
                    endcase
                end
            end
            S_OPC: begin
                o_cmd.latch_op = 1'b1;
                if (i_sts.kind == K_BAD) begin
                    o_cmd.set_unk = 1'b1;
                end else if (i_sts.mode == M_IMP) begin
                    if (i_sts.kind == K_RTS) begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_sel  = RS_STK;
                        o_cmd.sp_inc  = 1'b1;
                        o_cmd.set_bad = !i_sts.rd_ok;
                    end else begin
                        o_cmd.exec_imp = 1'b1;
                    end
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = RS_PC;
                    o_cmd.pc_inc  = 1'b1;
                    o_cmd.set_bad = !i_sts.rd_ok;
                end
            end
            S_OP1: begin
                case (i_sts.mode)
                    M_ZP: begin
                        o_cmd.rd_en     = 1'b1;
                        o_cmd.rd_sel    = RS_ZP;
                        o_cmd.set_ea_zp = 1'b1;
                        o_cmd.set_bad   = !i_sts.rd_ok;
                    end
                    M_ABS: begin
                        o_cmd.latch_lo = 1'b1;
                        o_cmd.rd_en    = 1'b1;
                        o_cmd.rd_sel   = RS_PC;
                        o_cmd.pc_inc   = 1'b1;
                        o_cmd.set_bad  = !i_sts.rd_ok;
                    end
                    default: o_cmd.exec_val = 1'b1;
                endcase
            end
            S_OP2: begin
                if (i_sts.kind == K_JMP) begin
                    o_cmd.pc_jmp = 1'b1;
                end else if (i_sts.kind == K_JSR) begin
                    o_cmd.set_ea_abs = 1'b1;
                    o_cmd.set_ret    = 1'b1;
                    o_cmd.set_bad    = !i_sts.stk_ok;
                end else begin
                    o_cmd.rd_en      = 1'b1;
                    o_cmd.rd_sel     = RS_ABS;
                    o_cmd.set_ea_abs = 1'b1;
                    o_cmd.set_bad    = !i_sts.rd_ok;
                end
            end
            S_MEM: begin
                o_cmd.exec_val = 1'b1;
                if (i_sts.kind == K_DEC || i_sts.kind == K_INC || i_sts.kind == K_LSRM) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WS_ALU;
                end
            end
            S_POP1: begin
                o_cmd.latch_lo = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = RS_STK;
                o_cmd.sp_inc   = 1'b1;
                o_cmd.set_bad  = !i_sts.rd_ok;
            end
            S_POP2: o_cmd.pc_pop = 1'b1;
            S_PUSH1: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_RET_HI;
                o_cmd.sp_dec = 1'b1;
            end
            S_PUSH2: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_RET_LO;
                o_cmd.sp_dec = 1'b1;
                o_cmd.pc_ea  = 1'b1;
            end
            S_FIN: o_cmd.finish = w_out_free;
            default: ;
        endcase
    end

    assign n_out_valid = o_cmd.finish || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !r_out_valid) |=> (r_state == S_IDLE && o_valid))
        else $error("finished item did not reach the output register");
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_FIN)
        else $error("output beat raised outside the finish state");
    a_exec_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_func == FN_EXEC) |=> r_state != S_IDLE)
        else $error("execute beat left the controller idle");
    a_push_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PUSH1 |=> r_state == S_PUSH2)
        else $error("return address push split");
`endif

endmodule

`default_nettype wire

[tb/tb_mos6502_subset_core_top.sv]
// Testbench for the 6502 subset core: loads small programs into memory, executes them
// and checks every result beat against an in-bench instruction predictor.
// Depends on mos_pkg and the mos6502_subset_core_top RTL.
`timescale 1ns / 100ps

import mos_pkg::*;

class cpu_scoreboard;
    logic [7:0]  mem [int];
    logic [15:0] pc;
    logic [7:0]  sp, acc, rx, ry, flg;
    t_out        pending [$];
    int          mismatches;
    int          results_seen;

    function void clear_regs();
        pc = 16'd0; sp = SP_RESET; acc = 8'd0; rx = 8'd0; ry = 8'd0; flg = 8'd0;
    endfunction

    function logic [7:0] peek(logic [15:0] a);
        if (mem.exists(a)) return mem[a];
        return 8'd0;
    endfunction

    function logic [7:0] zn(logic [7:0] f, logic [7:0] v);
        f = f & ~(FLAG_N | FLAG_Z);
        if (v == 8'd0) f = f | FLAG_Z;
        return f | (v & FLAG_N);
    endfunction

    function logic [7:0] cmpf(logic [7:0] f, logic [7:0] r, logic [7:0] v);
        f = zn(f, r - v) & ~FLAG_C;
        if (r >= v) f = f | FLAG_C;
        return f;
    endfunction

    function logic [7:0] lsrf(logic [7:0] f, logic [7:0] old);
        f = f & ~(FLAG_N | FLAG_Z | FLAG_C);
        f = f | (old & FLAG_C);
        if (old[7:1] == 7'd0) f = f | FLAG_Z;
        return f;
    endfunction

    function logic [7:0] next_byte(ref logic [15:0] p);
        logic [7:0] v;
        v = peek(p);
        p = p + 16'd1;
        return v;
    endfunction

    function logic [15:0] next_word(ref logic [15:0] p);
        logic [7:0] lo;
        lo = next_byte(p);
        return {next_byte(p), lo};
    endfunction

    function void note_item(t_in it);
        t_out        r;
        logic [15:0] p, ad, ret;
        logic [7:0]  op, v, lo;
        r = '0;
        if (it.func == FN_LOAD) begin
            mem[it.load_address] = it.load_data;
        end else if (it.func == FN_RESET) begin
            clear_regs();
        end else if (it.func == FN_EXEC) begin
            p = pc;
            op = next_byte(p);
            r.opcode_done = op;
            case (op)
                OPC_CLC: flg = flg & ~FLAG_C;
                OPC_CLD: flg = flg & ~FLAG_D;
                OPC_CLI: flg = flg & ~FLAG_I;
                OPC_CLV: flg = flg & ~FLAG_V;
                OPC_CMP_I: flg = cmpf(flg, acc, next_byte(p));
                OPC_CMP_Z: flg = cmpf(flg, acc, peek(16'(next_byte(p))));
                OPC_CMP_A: flg = cmpf(flg, acc, peek(next_word(p)));
                OPC_CPX_I: flg = cmpf(flg, rx, next_byte(p));
                OPC_CPX_Z: flg = cmpf(flg, rx, peek(16'(next_byte(p))));
                OPC_CPX_A: flg = cmpf(flg, rx, peek(next_word(p)));
                OPC_CPY_I: flg = cmpf(flg, ry, next_byte(p));
                OPC_CPY_Z: flg = cmpf(flg, ry, peek(16'(next_byte(p))));
                OPC_CPY_A: flg = cmpf(flg, ry, peek(next_word(p)));
                OPC_DEC_Z, OPC_DEC_A, OPC_INC_Z, OPC_INC_A: begin
                    ad = (op == OPC_DEC_Z || op == OPC_INC_Z) ? 16'(next_byte(p))
                                                              : next_word(p);
                    v = (op == OPC_DEC_Z || op == OPC_DEC_A) ? peek(ad) - 8'd1
                                                             : peek(ad) + 8'd1;
                    mem[ad] = v;
                    flg = zn(flg, v);
                end
                OPC_LSR_Z, OPC_LSR_A: begin
                    ad = (op == OPC_LSR_Z) ? 16'(next_byte(p)) : next_word(p);
                    v = peek(ad);
                    flg = lsrf(flg, v);
                    mem[ad] = v >> 1;
                end
                OPC_LSR_R: begin flg = lsrf(flg, acc); acc = acc >> 1; end
                OPC_DEX: begin rx = rx - 8'd1; flg = zn(flg, rx); end
                OPC_DEY: begin ry = ry - 8'd1; flg = zn(flg, ry); end
                OPC_INX: begin rx = rx + 8'd1; flg = zn(flg, rx); end
                OPC_INY: begin ry = ry + 8'd1; flg = zn(flg, ry); end
                OPC_EOR_I: begin acc = acc ^ next_byte(p); flg = zn(flg, acc); end
                OPC_EOR_Z: begin acc = acc ^ peek(16'(next_byte(p))); flg = zn(flg, acc); end
                OPC_EOR_A: begin acc = acc ^ peek(next_word(p)); flg = zn(flg, acc); end
                OPC_LDA_I: begin acc = next_byte(p); flg = zn(flg, acc); end
                OPC_LDA_Z: begin acc = peek(16'(next_byte(p))); flg = zn(flg, acc); end
                OPC_LDX_I: begin rx = next_byte(p); flg = zn(flg, rx); end
                OPC_LDX_Z: begin rx = peek(16'(next_byte(p))); flg = zn(flg, rx); end
                OPC_LDY_I: begin ry = next_byte(p); flg = zn(flg, ry); end
                OPC_LDY_Z: begin ry = peek(16'(next_byte(p))); flg = zn(flg, ry); end
                OPC_JMP: p = next_word(p);
                OPC_JSR: begin
                    ret = p + 16'd1;
                    mem[{STACK_PAGE, sp}] = ret[15:8];
                    sp = sp - 8'd1;
                    mem[{STACK_PAGE, sp}] = ret[7:0];
                    sp = sp - 8'd1;
                    p = next_word(p);
                end
                OPC_RTS: begin
                    sp = sp + 8'd1;
                    lo = peek({STACK_PAGE, sp});
                    sp = sp + 8'd1;
                    p = {peek({STACK_PAGE, sp}), lo} + 16'd1;
                end
                OPC_NOP: ;
                default: r.error_code = ERR_OP;
            endcase
            pc = p;
            flg = flg & FLAG_MASK;
        end
        r.program_counter = pc;
        r.accumulator = acc;
        r.index_x = rx;
        r.index_y = ry;
        r.stack_pointer = sp;
        r.status_flags = flg & FLAG_MASK;
        pending.push_back(r);
    endfunction

    function void check_result(t_out got);
        t_out want;
        results_seen++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
            return;
        end
        want = pending.pop_front();
        if (got.program_counter !== want.program_counter ||
            got.accumulator !== want.accumulator || got.index_x !== want.index_x ||
            got.index_y !== want.index_y || got.stack_pointer !== want.stack_pointer ||
            got.status_flags !== want.status_flags ||
            got.opcode_done !== want.opcode_done || got.error_code !== want.error_code) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: expected pc %h a %h x %h y %h sp %h f %h op %h err %0d, got pc %h a %h x %h y %h sp %h f %h op %h err %0d",
                         results_seen, want.program_counter, want.accumulator,
                         want.index_x, want.index_y, want.stack_pointer,
                         want.status_flags, want.opcode_done, want.error_code,
                         got.program_counter, got.accumulator, got.index_x,
                         got.index_y, got.stack_pointer, got.status_flags,
                         got.opcode_done, got.error_code);
        end
    endfunction
endclass

module tb_mos6502_subset_core_top;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_stall;
    t_in   i_data = '0;
    logic  o_valid;
    logic  i_stall = 1'b1;
    t_out  o_data;

    cpu_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int items_sent = 0;
    int execs_sent = 0;

    logic [7:0] ops_known [37] = '{
        OPC_CLC, OPC_CLD, OPC_CLI, OPC_CLV, OPC_CMP_I, OPC_CMP_Z, OPC_CMP_A,
        OPC_CPX_I, OPC_CPX_Z, OPC_CPX_A, OPC_CPY_I, OPC_CPY_Z, OPC_CPY_A,
        OPC_DEC_Z, OPC_DEC_A, OPC_INC_Z, OPC_INC_A, OPC_LSR_Z, OPC_LSR_A,
        OPC_LSR_R, OPC_DEX, OPC_DEY, OPC_INX, OPC_INY, OPC_EOR_I, OPC_EOR_Z,
        OPC_EOR_A, OPC_LDA_I, OPC_LDA_Z, OPC_LDX_I, OPC_LDX_Z, OPC_LDY_I,
        OPC_LDY_Z, OPC_JMP, OPC_JSR, OPC_RTS, OPC_NOP
    };

    mos6502_subset_core_top u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !i_rst_n || ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_beat(input logic [1:0] fn, input logic [15:0] addr,
                             input logic [7:0] dat);
        t_in it;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        it.func = fn;
        it.load_address = addr;
        it.load_data = dat;
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_item(it);
        items_sent++;
        if (fn == FN_EXEC) execs_sent++;
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic poke(input logic [15:0] a, input logic [7:0] d);
        send_beat(FN_LOAD, a, d);
    endtask

    task automatic run_one();
        send_beat(FN_EXEC, 16'd0, 8'd0);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Place one instruction at the given address with its operands, keeping the stack page in a known
    // state by first writing both bytes the next pull would read.
    task automatic place_at(input logic [15:0] at, input logic [7:0] op);
        logic [15:0] target;
        logic [7:0]  zp;
        zp = $urandom_range(255);
        poke(16'(zp), $urandom_range(255));
        target = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                          : 16'($urandom_range(16'h0400, 16'h0fff));
        if (op != OPC_JMP && op != OPC_JSR) poke(target, $urandom_range(255));
        poke({STACK_PAGE, sb.sp + 8'd1}, $urandom_range(255));
        poke({STACK_PAGE, sb.sp + 8'd2}, $urandom_range(255));
        poke(at, op);
        poke(at + 16'd1, zp);
        poke(at + 16'd2, target[15:8]);
        if (op == OPC_CMP_A || op == OPC_CPX_A || op == OPC_CPY_A || op == OPC_EOR_A ||
            op == OPC_DEC_A || op == OPC_INC_A || op == OPC_LSR_A || op == OPC_JMP ||
            op == OPC_JSR)
            poke(at + 16'd1, target[7:0]);
    endtask

    task automatic exec_op(input logic [7:0] op);
        place_at(sb.pc, op);
        run_one();
    endtask

    initial begin
        int k;
        logic [7:0] op;
        logic [7:0] b1, b2;
        sb = new();
        sb.clear_regs();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: memory extremes, register reset, every opcode, unknown opcode,
        // the unused func code and PC wrap from the top of memory.
        poke(16'hFFFF, 8'hFF);
        poke(16'h0000, OPC_LDA_I);
        poke(16'h0001, 8'h80);
        run_one();
        exec_op(OPC_LDX_I);
        exec_op(OPC_LDY_I);
        exec_op(OPC_CMP_I);
        exec_op(OPC_JSR);
        exec_op(OPC_RTS);
        exec_op(8'h02);
        send_beat(2'd3, 16'hFFFF, 8'hFF);
        poke(16'hFFFF, OPC_NOP);
        poke(sb.pc, OPC_NOP);
        send_beat(FN_EXEC, 16'hAAAA, 8'h55);
        send_beat(FN_RESET, 16'h5555, 8'hAA);
        poke(16'h0000, OPC_JMP);
        poke(16'h0001, 8'hFF);
        poke(16'h0002, 8'hFF);
        run_one();
        run_one();
        drain();
        foreach (ops_known[i]) exec_op(ops_known[i]);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 52 : 0;
            recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 32 : 0;
            if (phase == 2) begin
                @(negedge i_clk);
                hold_cycles = 400;
            end
            k = 0;
            while (k < 68) begin
                case ($urandom_range(19))
                    0: send_beat(FN_RESET, $urandom_range(65535), $urandom_range(255));
                    1: send_beat(2'd3, $urandom_range(65535), $urandom_range(255));
                    2: begin
                        op = 8'($urandom_range(255));
                        b1 = 8'($urandom_range(255));
                        b2 = 8'($urandom_range(255));
                        poke(16'(b1), 8'($urandom_range(255)));
                        poke({b2, b1}, 8'($urandom_range(255)));
                        poke({STACK_PAGE, sb.sp + 8'd1}, 8'($urandom_range(255)));
                        poke({STACK_PAGE, sb.sp + 8'd2}, 8'($urandom_range(255)));
                        poke(sb.pc, op);
                        poke(sb.pc + 16'd1, b1);
                        poke(sb.pc + 16'd2, b2);
                        run_one();
                    end
                    default: exec_op(ops_known[$urandom_range(36)]);
                endcase
                k++;
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        $display("covered %0d input beats, %0d of them executes, across three idle mixes",
                 items_sent, execs_sent);
        $display("with a long output hold-off and drained pauses between phases");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d beats missing", sb.mismatches, sb.pending.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
